FILE: rtl/core/brf_pkg.sv
// Shared constants, opcodes, a helper function and controller/datapath
// structs for the byte ring buffer. No dependencies.
`default_nettype none

package brf_pkg;

	localparam int DEPTH      = 1024;
	localparam int GAP        = 8;
	localparam int STORE_SIZE = DEPTH + GAP;
	localparam int IDX_W      = 11;
	localparam int CNT_W      = 7;
	localparam int DATA_W     = 64;
	localparam int MAX_PUT    = 8;
	localparam int MAX_STREAM = 64;

	localparam logic [2:0] OP_PUT     = 3'd0;
	localparam logic [2:0] OP_GET     = 3'd1;
	localparam logic [2:0] OP_PEEK    = 3'd2;
	localparam logic [2:0] OP_REMOVE  = 3'd3;
	localparam logic [2:0] OP_ADVANCE = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;
	localparam logic [2:0] OP_STATUS  = 3'd6;

	typedef struct packed {
		logic capture;
		logic exec;
		logic put_wr;
		logic issue;
		logic resp;
	} brf_cmd_t;

	typedef struct packed {
		logic put_go;
		logic stream_go;
		logic put_last;
		logic rem_last;
	} brf_stat_t;

	// Both operands below STORE_SIZE.
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(STORE_SIZE)) begin
			s = s - (IDX_W+1)'(STORE_SIZE);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/brf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1032
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/brf_ctrl.sv
// Controller state machine for the byte ring buffer.
// Depends on brf_pkg for the command and status structs.
`default_nettype none

module brf_ctrl import brf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire brf_stat_t stat,
	output brf_cmd_t       cmd,
	output logic           busy
);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_PUT, S_STREAM, S_RESP} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					if (stat.put_go) begin
						state_q <= S_PUT;
					end else if (stat.stream_go) begin
						state_q <= S_STREAM;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_PUT: begin
					if (stat.put_last) begin
						state_q <= S_RESP;
					end
				end
				S_STREAM: begin
					if (stat.rem_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.put_wr  = (state_q == S_PUT);
	assign cmd.issue   = (state_q == S_STREAM);
	assign cmd.resp    = (state_q == S_RESP);
	assign busy        = busy_q;

endmodule

`default_nettype wire

FILE: rtl/core/brf_dp.sv
// Datapath for the byte ring buffer: indices, occupancy and span logic,
// byte store, stream pipeline and result registers. Uses brf_pkg, brf_ram.
`default_nettype none

module brf_dp import brf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire brf_cmd_t          cmd,
	output brf_stat_t              stat,
	input  wire logic [2:0]        opcode,
	input  wire logic [DATA_W-1:0] put_bytes,
	input  wire logic [CNT_W-1:0]  count,
	input  wire logic [IDX_W-1:0]  offset,
	output logic                   valid,
	output logic [7:0]             byte_out,
	output logic                   last,
	output logic                   ok,
	output logic [IDX_W-1:0]       used_bytes,
	output logic [IDX_W-1:0]       free_bytes,
	output logic [IDX_W-1:0]       span_read,
	output logic [IDX_W-1:0]       span_write
);

	localparam logic [IDX_W:0] SIZE_X  = (IDX_W+1)'(STORE_SIZE);
	localparam logic [IDX_W:0] TOTAL_X = (IDX_W+1)'(STORE_SIZE - GAP);
	localparam logic [IDX_W:0] GAP_X   = (IDX_W+1)'(GAP);

	logic [2:0]        op_q;
	logic [DATA_W-1:0] put_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  off_q;

	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic [IDX_W-1:0]  waddr_q;
	logic [2:0]        bidx_q;
	logic [IDX_W-1:0]  raddr_q;
	logic [CNT_W-1:0]  rem_q;
	logic              ok_q;
	logic              rd_s1;
	logic              last_s1;
	logic              valid_q;

	logic [IDX_W:0]    used_c;
	logic [IDX_W:0]    free_c;
	logic [IDX_W:0]    span_r_c;
	logic [IDX_W:0]    span_w_c;
	logic [IDX_W:0]    cnt_x;
	logic [IDX_W+1:0]  peek_end;
	logic              ok_c;
	logic              cnt_nz;
	logic [IDX_W-1:0]  waddr_nx;
	logic [IDX_W-1:0]  raddr_nx;
	logic [7:0]        rdata;

	// Occupancy and spans from the live indices.
	always_comb begin
		if (wr_idx_q >= rd_idx_q) begin
			used_c   = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
			span_r_c = used_c;
			if (rd_idx_q < IDX_W'(GAP)) begin
				if (SIZE_X - {1'b0, wr_idx_q} + {1'b0, rd_idx_q} > GAP_X) begin
					span_w_c = SIZE_X - {1'b0, wr_idx_q} + {1'b0, rd_idx_q} - GAP_X;
				end else begin
					span_w_c = '0;
				end
			end else begin
				span_w_c = SIZE_X - {1'b0, wr_idx_q};
			end
		end else begin
			used_c   = {1'b0, wr_idx_q} + SIZE_X - {1'b0, rd_idx_q};
			span_r_c = SIZE_X - {1'b0, rd_idx_q};
			if ({1'b0, rd_idx_q} > {1'b0, wr_idx_q} + GAP_X) begin
				span_w_c = {1'b0, rd_idx_q} - GAP_X - {1'b0, wr_idx_q};
			end else begin
				span_w_c = '0;
			end
		end
		free_c = (TOTAL_X > used_c) ? TOTAL_X - used_c : '0;
	end

	assign cnt_x    = (IDX_W+1)'(cnt_q);
	assign peek_end = {2'b00, off_q} + (IDX_W+2)'(cnt_q);
	assign cnt_nz   = (cnt_q != '0);

	always_comb begin
		case (op_q)
			OP_PUT:     ok_c = (cnt_q <= CNT_W'(MAX_PUT)) && (cnt_x <= free_c);
			OP_GET:     ok_c = (cnt_q <= CNT_W'(MAX_STREAM)) && (cnt_x <= used_c);
			OP_PEEK:    ok_c = (cnt_q <= CNT_W'(MAX_STREAM)) && (peek_end <= {1'b0, used_c});
			OP_REMOVE:  ok_c = (cnt_x <= used_c);
			OP_ADVANCE: ok_c = (cnt_x <= free_c);
			OP_CLEAR,
			OP_STATUS:  ok_c = 1'b1;
			default:    ok_c = 1'b0;
		endcase
	end

	assign stat.put_go    = (op_q == OP_PUT) && ok_c && cnt_nz;
	assign stat.stream_go = ((op_q == OP_GET) || (op_q == OP_PEEK)) && ok_c && cnt_nz;
	assign stat.put_last  = ((CNT_W'(bidx_q) + CNT_W'(1)) == cnt_q);
	assign stat.rem_last  = (rem_q == CNT_W'(1));

	assign waddr_nx = (waddr_q == IDX_W'(STORE_SIZE - 1)) ? '0 : waddr_q + IDX_W'(1);
	assign raddr_nx = (raddr_q == IDX_W'(STORE_SIZE - 1)) ? '0 : raddr_q + IDX_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			put_q <= put_bytes;
			cnt_q <= count;
			off_q <= offset;
		end
		if (cmd.exec) begin
			ok_q    <= ok_c;
			waddr_q <= wr_idx_q;
			bidx_q  <= '0;
			rem_q   <= cnt_q;
			if (op_q == OP_PEEK) begin
				raddr_q <= wrap_add(rd_idx_q, off_q);
			end else begin
				raddr_q <= rd_idx_q;
			end
		end
		if (cmd.put_wr) begin
			waddr_q <= waddr_nx;
			bidx_q  <= bidx_q + 3'd1;
		end
		if (cmd.issue) begin
			raddr_q <= raddr_nx;
			rem_q   <= rem_q - CNT_W'(1);
		end
		last_s1 <= stat.rem_last;
		if (rd_s1) begin
			byte_out <= rdata;
			last     <= last_s1;
			ok       <= 1'b1;
		end else if (cmd.resp) begin
			byte_out <= '0;
			last     <= 1'b1;
			ok       <= ok_q;
		end
		if (rd_s1 || cmd.resp) begin
			used_bytes <= used_c[IDX_W-1:0];
			free_bytes <= free_c[IDX_W-1:0];
			span_read  <= span_r_c[IDX_W-1:0];
			span_write <= span_w_c[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			rd_s1    <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			rd_s1   <= cmd.issue;
			valid_q <= rd_s1 || cmd.resp;
			if (cmd.exec && ok_c) begin
				case (op_q)
					OP_GET,
					OP_REMOVE:  rd_idx_q <= wrap_add(rd_idx_q, IDX_W'(cnt_q));
					OP_ADVANCE: wr_idx_q <= wrap_add(wr_idx_q, IDX_W'(cnt_q));
					OP_CLEAR: begin
						rd_idx_q <= '0;
						wr_idx_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.put_wr && stat.put_last) begin
				wr_idx_q <= waddr_nx;
			end
		end
	end

	brf_ram #(
		.WIDTH (8),
		.DEPTH (STORE_SIZE)
	) u_store (
		.clk   (clk),
		.we    (cmd.put_wr),
		.waddr (waddr_q),
		.wdata (put_q[{bidx_q, 3'b000} +: 8]),
		.raddr (raddr_q),
		.rdata (rdata)
	);

	assign valid = valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/byte_ring_fifo_with_peek.sv
// Top level of the byte ring buffer with peek: controller plus datapath.
// Uses brf_pkg, brf_ctrl, brf_dp (which holds the brf_ram byte store).
//
//   beat     | handshake      | payload
//   ---------+----------------+------------------------------------------
//   command  | start / busy   | opcode, put_bytes, count, offset
//   result   | valid (strobe) | byte_out, last, ok, used_bytes,
//            |                | free_bytes, span_read, span_write
//
// A command is taken when start is high and busy is low.
// Status-only commands and refused commands: one result beat, driven from
// the response state that follows the execute state. Put: byte writes (one
// per cycle on the store write port), then one result beat. Get and peek:
// one result per cycle from the store read port, each byte passing the read
// address register, the registered store read and the output register.
// Results are strobed for one cycle; the receiver
// cannot stall. Reset clears both indices; the store is not cleared.
`default_nettype none

module byte_ring_fifo_with_peek import brf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [2:0]        opcode,
	input  wire logic [DATA_W-1:0] put_bytes,
	input  wire logic [CNT_W-1:0]  count,
	input  wire logic [IDX_W-1:0]  offset,
	output logic                   valid,
	output logic [7:0]             byte_out,
	output logic                   last,
	output logic                   ok,
	output logic [IDX_W-1:0]       used_bytes,
	output logic [IDX_W-1:0]       free_bytes,
	output logic [IDX_W-1:0]       span_read,
	output logic [IDX_W-1:0]       span_write
);

	brf_cmd_t  cmd;
	brf_stat_t stat;

	brf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	brf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.opcode     (opcode),
		.put_bytes  (put_bytes),
		.count      (count),
		.offset     (offset),
		.valid      (valid),
		.byte_out   (byte_out),
		.last       (last),
		.ok         (ok),
		.used_bytes (used_bytes),
		.free_bytes (free_bytes),
		.span_read  (span_read),
		.span_write (span_write)
	);

endmodule

`default_nettype wire

FILE: rtl/core/brf_checker.sv
// Port-level checks for the byte ring buffer, bound to the top level.
// Uses brf_pkg.
`default_nettype none

module brf_checker import brf_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              valid,
	input wire logic [7:0]        byte_out,
	input wire logic              last,
	input wire logic              ok,
	input wire logic [IDX_W-1:0]  used_bytes,
	input wire logic [IDX_W-1:0]  free_bytes
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	a_refuse_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !ok) |-> last)
		else $error("refused beat without last");

	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !ok) |-> (byte_out == 8'd0))
		else $error("refused beat carries data");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (({1'b0, used_bytes} + {1'b0, free_bytes}) == (IDX_W+1)'(DEPTH)))
		else $error("used plus free differs from capacity");

endmodule

bind byte_ring_fifo_with_peek brf_checker u_brf_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for byte_ring_fifo_with_peek: directed and random command
// beats, every reply beat checked field by field against a software ring kept here.
// Depends on brf_pkg and the byte_ring_fifo_with_peek RTL.
`default_nettype none

module testbench;
	import brf_pkg::*;

	localparam logic [2:0] OP_UNDEFINED = 3'd7;

	typedef struct {
		logic [7:0]       data;
		logic             last;
		logic             ok;
		logic [IDX_W-1:0] used;
		logic [IDX_W-1:0] free;
		logic [IDX_W-1:0] span_rd;
		logic [IDX_W-1:0] span_wr;
	} reply_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        opcode;
	logic [DATA_W-1:0] put_bytes;
	logic [CNT_W-1:0]  count;
	logic [IDX_W-1:0]  offset;
	logic              valid;
	logic [7:0]        byte_out;
	logic              last;
	logic              ok;
	logic [IDX_W-1:0]  used_bytes;
	logic [IDX_W-1:0]  free_bytes;
	logic [IDX_W-1:0]  span_read;
	logic [IDX_W-1:0]  span_write;

	logic [7:0] ring_mem [STORE_SIZE];
	bit         ring_known [STORE_SIZE];
	int         rd_pos = 0;
	int         wr_pos = 0;
	reply_t     replies_due [$];
	reply_t     due;
	int         mismatch_count = 0;
	int         gap_max = 13;

	byte_ring_fifo_with_peek DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.put_bytes  (put_bytes),
		.count      (count),
		.offset     (offset),
		.valid      (valid),
		.byte_out   (byte_out),
		.last       (last),
		.ok         (ok),
		.used_bytes (used_bytes),
		.free_bytes (free_bytes),
		.span_read  (span_read),
		.span_write (span_write)
	);

	always #10 clk = ~clk;

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	function automatic int ring_used();
		if (wr_pos >= rd_pos) begin
			return wr_pos - rd_pos;
		end
		return wr_pos + STORE_SIZE - rd_pos;
	endfunction

	function automatic int ring_free();
		int total;
		int u;
		total = STORE_SIZE - GAP;
		u = ring_used();
		return (total > u) ? total - u : 0;
	endfunction

	function automatic int ring_span_rd();
		if (wr_pos >= rd_pos) begin
			return wr_pos - rd_pos;
		end
		return STORE_SIZE - rd_pos;
	endfunction

	function automatic int ring_span_wr();
		int lim;
		int s;
		lim = rd_pos - GAP;
		if (wr_pos >= rd_pos) begin
			s = (lim < 0) ? STORE_SIZE - wr_pos + lim : STORE_SIZE - wr_pos;
		end else begin
			s = lim - wr_pos;
		end
		return (s < 0) ? 0 : s;
	endfunction

	function automatic bit bytes_known(input int first, input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if (!ring_known[(first + i) % STORE_SIZE]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic bit reads_unknown(input logic [2:0] op, input int n, input int o);
		if (op == OP_GET) begin
			return n <= MAX_STREAM && n <= ring_used() && !bytes_known(rd_pos, n);
		end
		if (op == OP_PEEK) begin
			return n <= MAX_STREAM && o + n <= ring_used() && !bytes_known(rd_pos + o, n);
		end
		return 1'b0;
	endfunction

	task automatic emit_reply(input logic [7:0] data, input logic is_last, input logic granted);
		reply_t r;
		r.data    = data;
		r.last    = is_last;
		r.ok      = granted;
		r.used    = IDX_W'(ring_used());
		r.free    = IDX_W'(ring_free());
		r.span_rd = IDX_W'(ring_span_rd());
		r.span_wr = IDX_W'(ring_span_wr());
		replies_due.push_back(r);
	endtask

	task automatic apply_ring_op(input logic [2:0] op, input logic [DATA_W-1:0] data,
		input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] off);
		int  n;
		int  o;
		int  i;
		int  first;
		bit  granted;
		bit  streamed;
		n = cnt;
		o = off;
		first = 0;
		granted = 1'b0;
		streamed = 1'b0;
		case (op)
			OP_PUT: begin
				if (n <= MAX_PUT && n <= ring_free()) begin
					for (i = 0; i < n; i++) begin
						ring_mem[(wr_pos + i) % STORE_SIZE] = data[8*i +: 8];
						ring_known[(wr_pos + i) % STORE_SIZE] = 1'b1;
					end
					wr_pos = (wr_pos + n) % STORE_SIZE;
					granted = 1'b1;
				end
			end
			OP_GET: begin
				if (n <= MAX_STREAM && n <= ring_used()) begin
					granted = 1'b1;
					if (n > 0) begin
						first = rd_pos;
						rd_pos = (rd_pos + n) % STORE_SIZE;
						streamed = 1'b1;
					end
				end
			end
			OP_PEEK: begin
				if (n <= MAX_STREAM && o + n <= ring_used()) begin
					granted = 1'b1;
					if (n > 0) begin
						first = rd_pos + o;
						streamed = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				if (n <= ring_used()) begin
					rd_pos = (rd_pos + n) % STORE_SIZE;
					granted = 1'b1;
				end
			end
			OP_ADVANCE: begin
				if (n <= ring_free()) begin
					wr_pos = (wr_pos + n) % STORE_SIZE;
					granted = 1'b1;
				end
			end
			OP_CLEAR: begin
				rd_pos = 0;
				wr_pos = 0;
				granted = 1'b1;
			end
			OP_STATUS: begin
				granted = 1'b1;
			end
			default: begin
				granted = 1'b0;
			end
		endcase
		if (streamed) begin
			for (i = 0; i < n; i++) begin
				emit_reply(ring_mem[(first + i) % STORE_SIZE], i == n - 1, 1'b1);
			end
		end else begin
			emit_reply(8'h00, 1'b1, granted);
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
	endtask

	task automatic issue_cmd(input logic [2:0] op, input logic [DATA_W-1:0] data,
		input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] off);
		int idle;
		idle = $urandom_range(0, gap_max);
		if (idle > 0) begin
			start <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		put_bytes <= data;
		count     <= cnt;
		offset    <= off;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_ring_op(op, data, cnt, off);
	endtask

	always @(posedge clk) begin
		if (arst_n && valid === 1'b1) begin
			if (replies_due.size() == 0) begin
				report_mismatch("reply beat with no command outstanding");
			end else begin
				due = replies_due.pop_front();
				if (byte_out !== due.data)
					report_mismatch($sformatf("byte_out %0h, want %0h", byte_out, due.data));
				if (last !== due.last)
					report_mismatch($sformatf("last %0b, want %0b", last, due.last));
				if (ok !== due.ok)
					report_mismatch($sformatf("ok %0b, want %0b", ok, due.ok));
				if (used_bytes !== due.used)
					report_mismatch($sformatf("used_bytes %0d, want %0d", used_bytes, due.used));
				if (free_bytes !== due.free)
					report_mismatch($sformatf("free_bytes %0d, want %0d", free_bytes, due.free));
				if (span_read !== due.span_rd)
					report_mismatch($sformatf("span_read %0d, want %0d", span_read, due.span_rd));
				if (span_write !== due.span_wr)
					report_mismatch($sformatf("span_write %0d, want %0d", span_write,
						due.span_wr));
			end
		end
	end

	task automatic test_empty_ring();
		issue_cmd(OP_STATUS, '0, '0, '0);
		issue_cmd(OP_GET, '0, '0, '0);
		issue_cmd(OP_PEEK, '0, '0, '0);
		issue_cmd(OP_REMOVE, '0, '0, '0);
		issue_cmd(OP_ADVANCE, '0, '0, '0);
		issue_cmd(OP_GET, '0, 7'd1, '0);
		issue_cmd(OP_PEEK, '0, 7'd1, '0);
		issue_cmd(OP_REMOVE, '0, 7'd1, '0);
		issue_cmd(OP_UNDEFINED, {$urandom, $urandom}, 7'd5, 11'd3);
	endtask

	task automatic test_put_and_peek();
		issue_cmd(OP_PUT, {$urandom, $urandom}, '0, '0);
		issue_cmd(OP_PUT, '1, 7'd8, '0);
		issue_cmd(OP_PUT, '1, 7'd9, '0);
		issue_cmd(OP_PUT, {$urandom, $urandom}, 7'd3, '0);
		issue_cmd(OP_PEEK, '0, 7'd6, 11'd2);
		issue_cmd(OP_PEEK, '0, 7'd2, 11'd10);
		issue_cmd(OP_PEEK, '0, 7'd65, '0);
		issue_cmd(OP_GET, '0, 7'd65, '0);
		issue_cmd(OP_GET, '0, 7'd11, '0);
	endtask

	task automatic test_full_and_wrap();
		int k;
		issue_cmd(OP_CLEAR, '0, '0, '0);
		for (k = 0; k < 8; k++) begin
			issue_cmd(OP_ADVANCE, '0, 7'd127, '0);
		end
		issue_cmd(OP_ADVANCE, '0, 7'd8, '0);
		issue_cmd(OP_PUT, {$urandom, $urandom}, 7'd1, '0);
		issue_cmd(OP_ADVANCE, '0, 7'd1, '0);
		issue_cmd(OP_PUT, '1, '0, '0);
		issue_cmd(OP_PEEK, '0, '0, 11'd1024);
		for (k = 0; k < 8; k++) begin
			issue_cmd(OP_REMOVE, '0, 7'd127, '0);
		end
		issue_cmd(OP_REMOVE, '0, 7'd8, '0);
		issue_cmd(OP_PUT, 64'h8877_6655_4433_2211, 7'd8, '0);
		issue_cmd(OP_PUT, {$urandom, $urandom}, 7'd8, '0);
		issue_cmd(OP_PEEK, '0, 7'd8, 11'd4);
		issue_cmd(OP_GET, '0, 7'd16, '0);
	endtask

	function automatic int pick_read_count(input int avail);
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(0, 127);
		end
		if (avail <= 0) begin
			return $urandom_range(0, 1);
		end
		if ($urandom_range(0, 5) == 0) begin
			return $urandom_range(1, min_int(avail, MAX_STREAM));
		end
		return $urandom_range(1, min_int(avail, 12));
	endfunction

	task automatic test_random_traffic(input int n_items);
		int         k;
		int         pick;
		int         used_now;
		int         room;
		int         n;
		int         o;
		int         put_share;
		logic [2:0] op;
		put_share = 40;
		for (k = 0; k < n_items; k++) begin
			if (k % 30 == 0) begin
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
				put_share = ($urandom_range(0, 1) == 0) ? 40 : 52;
			end
			used_now = ring_used();
			room = ring_free();
			n = 0;
			o = 0;
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				op = 3'($urandom_range(0, 7));
				n = $urandom_range(0, 127);
				o = $urandom_range(0, 2047);
			end else if (pick < 5 + put_share) begin
				op = OP_PUT;
				n = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127)
					: $urandom_range(1, MAX_PUT);
			end else if (pick < 23 + put_share) begin
				op = OP_GET;
				n = pick_read_count(used_now);
			end else if (pick < 35 + put_share) begin
				op = OP_PEEK;
				if ($urandom_range(0, 9) == 0) begin
					o = $urandom_range(0, 2047);
				end else if (used_now > 0) begin
					o = $urandom_range(0, min_int(used_now - 1, 40));
				end
				n = pick_read_count(used_now - o);
			end else if (pick < 40 + put_share) begin
				op = OP_REMOVE;
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
					: $urandom_range(0, min_int(used_now, 40));
			end else if (pick < 44 + put_share) begin
				op = OP_ADVANCE;
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
					: $urandom_range(0, min_int(room, 16));
			end else if (pick < 46 + put_share) begin
				op = OP_CLEAR;
			end else if (pick < 48 + put_share) begin
				op = OP_UNDEFINED;
			end else begin
				op = OP_STATUS;
			end
			if (reads_unknown(op, n, o)) begin
				op = (op == OP_GET) ? OP_REMOVE : OP_STATUS;
			end
			issue_cmd(op, {$urandom, $urandom}, CNT_W'(n), IDX_W'(o));
		end
	endtask

	task automatic wait_for_replies();
		int waited;
		start <= 1'b0;
		waited = 0;
		while (replies_due.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (replies_due.size() != 0) begin
			report_mismatch($sformatf("%0d reply beats never arrived", replies_due.size()));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		opcode    = OP_STATUS;
		put_bytes = '0;
		count     = '0;
		offset    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_ring();
		test_put_and_peek();
		test_full_and_wrap();
		test_random_traffic(265);
		wait_for_replies();
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
